FILE: src/iss_pkg.sv
// Shared types and constants for the insertion sorter.
package iss_pkg;

    localparam int ISS_CAPACITY = 16;
    localparam int ISS_WIDTH    = 32;

    typedef struct packed {
        logic signed [ISS_WIDTH-1:0] value;
        logic                        last;
    } t_in_item;

    typedef struct packed {
        logic signed [ISS_WIDTH-1:0] value_res;
        logic                        last_res;
        logic                        overflow;
    } t_out_item;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic                        valid;
        logic                        gt;     // holds a value greater than the incoming one
        logic signed [ISS_WIDTH-1:0] value;
    } t_link;

endpackage

FILE: src/insertion_sorter_unit.sv
// Top level of the streaming insertion sorter: cell chain, drain control, output register.
//
// Input channel: i_valid / o_stall carrying i_item (signed value and last flag).
// Output channel: o_valid / i_stall carrying o_item (value_res, last_res, overflow).
// An item moves on a rising edge where valid is high and stall is low.
//
// Load phase: one item per cycle. Each item is compared against every cell at
// once; larger cells move up by one and the new value drops into the gap, so
// equal values keep arrival order. An item that arrives with all CAPACITY cells
// full is dropped and the set's overflow flag is raised.
// Drain phase: entered after the item marked last. The chain shifts toward
// cell 0 one position per cycle into the output register, giving one result
// per cycle in ascending order; the final result carries last_res. o_stall is
// high for the whole drain, so no new item is taken until the drain ends.
// When the receiver stalls, the output register holds and the chain holds.
// Reset (synchronous, active low) empties the chain and clears overflow and
// the output register valid.
module insertion_sorter_unit #(
    parameter int CAPACITY = iss_pkg::ISS_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  iss_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output iss_pkg::t_out_item o_item
);
    import iss_pkg::*;

    typedef enum logic {
        S_LOAD,
        S_DRAIN
    } t_state;

    t_state             r_state;
    logic               r_drop;
    logic               r_out_valid;
    t_out_item          r_out;

    t_link              w_link [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic               w_in_acc;
    logic               w_full;
    logic               w_insert;
    logic               w_step;
    logic               w_end;

    // Input is taken only during load; drain blocks new items.
    assign o_stall  = (r_state != S_LOAD);
    assign w_in_acc = i_valid && !o_stall;
    assign w_full   = w_link[CAPACITY-1].valid;
    assign w_insert = w_in_acc && !w_full;

    // Advance the drain whenever the output register is free or being taken.
    assign w_step = (r_state == S_DRAIN) && (!r_out_valid || !i_stall);
    assign w_end  = !w_link[1].valid;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_link w_lower;
            t_link w_upper;

            if (g == 0) begin : g_bottom
                // Below cell 0 sits a virtual occupied cell that is never larger.
                assign w_lower = '{valid: 1'b1, gt: 1'b0, value: '0};
            end else begin : g_mid_lo
                assign w_lower = w_link[g-1];
            end

            if (g == CAPACITY - 1) begin : g_top
                assign w_upper = '0;
            end else begin : g_mid_hi
                assign w_upper = w_link[g+1];
            end

            iss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_insert(w_insert),
                .i_shift (w_step),
                .i_value (i_item.value),
                .i_lower (w_lower),
                .i_upper (w_upper),
                .o_link  (w_link[g])
            );

            assign w_valid[g] = w_link[g].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (w_full) begin
                            r_drop <= 1'b1;
                        end
                        if (i_item.last) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    // Drop back to load once the final element leaves cell 0.
                    if (w_step && w_end) begin
                        r_state <= S_LOAD;
                        r_drop  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase

            if (w_step) begin
                r_out_valid     <= 1'b1;
                r_out.value_res <= w_link[0].value;
                r_out.last_res  <= w_end;
                r_out.overflow  <= r_drop;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // Occupied cells always form a run starting at cell 0.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid & (w_valid + 1'b1)) == '0))
        else $error("occupied cells are not contiguous");

    // Drain never starts on an empty chain.
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> w_valid[0])
        else $error("drain with empty chain");

    // The step that emits the final element leaves the chain empty and loading.
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_end) |=> (r_state == S_LOAD) && (w_valid == '0) && !r_drop)
        else $error("chain not cleared after final element");

    // An accepted last item always starts a drain.
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_item.last) |=> (r_state == S_DRAIN))
        else $error("last item did not start drain");

endmodule

FILE: src/iss_cell.sv
// One cell of the insertion chain: holds one sorted value and its valid bit.
module iss_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_insert,
    input  logic                                 i_shift,
    input  logic signed [iss_pkg::ISS_WIDTH-1:0] i_value,
    input  iss_pkg::t_link                       i_lower,
    input  iss_pkg::t_link                       i_upper,
    output iss_pkg::t_link                       o_link
);
    import iss_pkg::*;

    logic                        r_valid;
    logic signed [ISS_WIDTH-1:0] r_value;
    logic                        w_gt;
    logic                        w_take;

    assign w_gt = r_valid && ($signed(r_value) > $signed(i_value));

    // Take a new value when this cell is empty or larger, and the lower cell is occupied.
    assign w_take = i_insert && (!r_valid || w_gt) && i_lower.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_upper.valid;
            r_value <= i_upper.value;
        end else if (w_take) begin
            r_valid <= 1'b1;
            r_value <= i_lower.gt ? i_lower.value : i_value;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;
    assign o_link.value = r_value;

endmodule
